// ----- design/are_pkg.sv -----
// Shared types and constants for the ARP resolver engine.
// Used by are_cell and arp_resolver_engine_top; depends on nothing.
`default_nettype none
package are_pkg;

   localparam int CACHE_ENTRIES   = 16;
   localparam int PENDING_ENTRIES = 8;
   localparam int MAX_ENTRIES     = (CACHE_ENTRIES > PENDING_ENTRIES) ?
                                    CACHE_ENTRIES : PENDING_ENTRIES;
   localparam int IDX_W           = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [1:0] CMD_FRAME    = 2'd0;
   localparam logic [1:0] CMD_OUTBOUND = 2'd1;
   localparam logic [1:0] CMD_TICK     = 2'd2;
   localparam logic [1:0] CMD_ANNOUNCE = 2'd3;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_REJECT  = 3'd1;
   localparam logic [2:0] ACT_FORWARD = 3'd2;
   localparam logic [2:0] ACT_REQUEST = 3'd3;
   localparam logic [2:0] ACT_DROP    = 3'd4;
   localparam logic [2:0] ACT_REPLY   = 3'd5;
   localparam logic [2:0] ACT_RELEASE = 3'd6;

   localparam logic [1:0] REG_OWN_IP       = 2'd0;
   localparam logic [1:0] REG_OWN_MAC      = 2'd1;
   localparam logic [1:0] REG_CACHE_TO     = 2'd2;
   localparam logic [1:0] REG_PEND_TO      = 2'd3;

   localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

   // Search record that walks down a row of cells, one cell per cycle.
   typedef struct packed {
      logic             go;
      logic [31:0]      key;
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             hit_live;
      logic [47:0]      hit_mac;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic             exp;
      logic [IDX_W-1:0] exp_idx;
      logic [IDX_W-1:0] best_idx;
      logic [31:0]      best_age;
   } rec_type;

   // Update broadcast to every cell of a row.
   typedef struct packed {
      logic             en;
      logic             clr;
      logic             sweep;
      logic [IDX_W-1:0] idx;
      logic [31:0]      ip;
      logic [47:0]      mac;
      logic [31:0]      stamp;
   } wr_type;

endpackage
`default_nettype wire

// ----- design/arp_resolver_engine_top.sv -----
// Top level of the ARP resolver engine: command decode, two rows of
// are_cell (cache and pending), result registers. Depends on are_pkg.
//
// Usage: drive a command on the req_ ports and raise start while busy is
// low; that beat is accepted. cmd selects a received ARP frame, an
// outbound packet, a one-second tick or an announce. Exactly one result
// follows per command, shown on the rsp_ ports for one cycle with
// rsp_valid high; the receiver cannot stall it.
// Frames and outbound packets send a search record down both rows of
// cells, one cell per cycle, so the cache row of CACHE_ENTRIES cells sets
// the time from accept to the next accept, with rsp_valid in the first
// cycle in which busy is low again. Ticks pass through a sweep state, and
// announces and rejected frames go straight to the finishing state.
// Configuration is written through csr_ at any idle cycle.
// Reset clears every valid bit, the tick counter and the registers to
// their defaults at once; no clearing pass is needed.
`default_nettype none
module arp_resolver_engine_top
   import are_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [10:0] req_frame_len,
   input  wire logic [15:0] req_hw_type,
   input  wire logic [15:0] req_proto_type,
   input  wire logic [7:0]  req_hw_addr_len,
   input  wire logic [7:0]  req_proto_addr_len,
   input  wire logic [15:0] req_arp_op,
   input  wire logic [47:0] req_sender_hw,
   input  wire logic [31:0] req_sender_proto,
   input  wire logic [31:0] req_target_proto,
   input  wire logic [31:0] req_next_hop_ip,
   output logic             rsp_valid,
   output logic [2:0]       rsp_action,
   output logic [47:0]      rsp_eth_dest,
   output logic [31:0]      rsp_arp_tgt_ip,
   output logic [47:0]      rsp_arp_tgt_mac,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_DECIDE = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] own_ip_ff;
   logic [47:0] own_mac_ff;
   logic [15:0] cache_to_ff, pend_to_ff;
   logic [31:0] now_ff;

   logic [1:0]  cmd_ff;
   logic        op_req_ff;
   logic [47:0] shw_ff;
   logic [31:0] sip_ff;
   logic [31:0] tgt_ff;
   logic [31:0] nh_ff;

   logic [2:0]  act_ff, act_in;
   logic [47:0] dest_ff, dest_in;
   logic [31:0] tip_ff, tip_in;
   logic [47:0] tmac_ff, tmac_in;
   logic        rsp_valid_ff;

   logic        accept, frame_ok, launch;
   rec_type     c_rec [0:CACHE_ENTRIES];
   rec_type     p_rec [0:PENDING_ENTRIES];
   rec_type     c_res_ff, p_res_ff;
   logic        c_done_ff, p_done_ff;
   wr_type      c_wr, p_wr;
   logic [IDX_W-1:0] c_pick, p_pick;
   logic        c_hit_live, p_hit_live;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign frame_ok = (req_frame_len >= 11'd28) && (req_hw_type == 16'h0001) &&
                     (req_proto_type == 16'h0800) && (req_hw_addr_len == 8'd6) &&
                     (req_proto_addr_len == 8'd4) &&
                     (req_arp_op == 16'd1 || req_arp_op == 16'd2);

   // Search record entering both rows.
   always_comb begin
      c_rec[0]     = '0;
      c_rec[0].go  = launch;
      c_rec[0].key = (req_cmd == CMD_FRAME) ? req_sender_proto : req_next_hop_ip;
      p_rec[0]     = c_rec[0];
   end

   genvar gi;
   generate
      for (gi = 0; gi < CACHE_ENTRIES; gi++) begin : g_cache
         are_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cell_idx  (IDX_W'(gi)),
            .now_ticks (now_ff),
            .timeout   (cache_to_ff),
            .wr        (c_wr),
            .rec_in    (c_rec[gi]),
            .rec_out   (c_rec[gi+1])
         );
      end
      for (gi = 0; gi < PENDING_ENTRIES; gi++) begin : g_pend
         are_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cell_idx  (IDX_W'(gi)),
            .now_ticks (now_ff),
            .timeout   (pend_to_ff),
            .wr        (p_wr),
            .rec_in    (p_rec[gi]),
            .rec_out   (p_rec[gi+1])
         );
      end
   endgenerate

   // Insertion order: same key, then free, then expired, then oldest.
   assign c_pick = c_res_ff.hit  ? c_res_ff.hit_idx  :
                   c_res_ff.free ? c_res_ff.free_idx :
                   c_res_ff.exp  ? c_res_ff.exp_idx  : c_res_ff.best_idx;
   assign p_pick = p_res_ff.hit  ? p_res_ff.hit_idx  :
                   p_res_ff.free ? p_res_ff.free_idx :
                   p_res_ff.exp  ? p_res_ff.exp_idx  : p_res_ff.best_idx;
   assign c_hit_live = c_res_ff.hit && c_res_ff.hit_live;
   assign p_hit_live = p_res_ff.hit && p_res_ff.hit_live;

   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      dest_in  = dest_ff;
      tip_in   = tip_ff;
      tmac_in  = tmac_ff;
      launch   = 1'b0;
      c_wr     = '0;
      p_wr     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in  = ACT_NONE;
               dest_in = '0;
               tip_in  = '0;
               tmac_in = '0;
               case (req_cmd)
                  CMD_FRAME: begin
                     if (frame_ok) begin
                        launch   = 1'b1;
                        state_in = ST_SCAN;
                     end else begin
                        act_in   = ACT_REJECT;
                        state_in = ST_FINISH;
                     end
                  end
                  CMD_OUTBOUND: begin
                     launch   = 1'b1;
                     state_in = ST_SCAN;
                  end
                  CMD_TICK: begin
                     state_in = ST_SWEEP;
                  end
                  default: begin
                     act_in   = ACT_REQUEST;
                     dest_in  = MAC_BCAST;
                     tip_in   = own_ip_ff;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (c_done_ff && p_done_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            if (cmd_ff == CMD_FRAME) begin
               c_wr.en    = 1'b1;
               c_wr.idx   = c_pick;
               c_wr.ip    = sip_ff;
               c_wr.mac   = shw_ff;
               c_wr.stamp = now_ff;
               if (p_hit_live) begin
                  p_wr.clr = 1'b1;
                  p_wr.idx = p_res_ff.hit_idx;
                  act_in   = ACT_RELEASE;
                  dest_in  = shw_ff;
               end else if (op_req_ff && tgt_ff == own_ip_ff) begin
                  act_in  = ACT_REPLY;
                  dest_in = shw_ff;
                  tip_in  = sip_ff;
                  tmac_in = shw_ff;
               end
            end else if (c_hit_live) begin
               act_in  = ACT_FORWARD;
               dest_in = c_res_ff.hit_mac;
            end else if (p_hit_live) begin
               act_in = ACT_DROP;
            end else begin
               p_wr.en    = 1'b1;
               p_wr.idx   = p_pick;
               p_wr.ip    = nh_ff;
               p_wr.stamp = now_ff;
               act_in     = ACT_REQUEST;
               dest_in    = MAC_BCAST;
               tip_in     = nh_ff;
            end
         end
         ST_SWEEP: begin
            // The tick count has already advanced when the rows are swept.
            c_wr.sweep = 1'b1;
            p_wr.sweep = 1'b1;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         c_done_ff    <= 1'b0;
         p_done_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FINISH);
         if (accept && req_cmd == CMD_TICK) begin
            now_ff <= now_ff + 32'd1;
         end
         if (launch) begin
            c_done_ff <= 1'b0;
         end else if (c_rec[CACHE_ENTRIES].go) begin
            c_done_ff <= 1'b1;
         end
         if (launch) begin
            p_done_ff <= 1'b0;
         end else if (p_rec[PENDING_ENTRIES].go) begin
            p_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff   <= '0;
         own_mac_ff  <= '0;
         cache_to_ff <= 16'd60;
         pend_to_ff  <= 16'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_OWN_IP:   own_ip_ff   <= csr_wdata[31:0];
            REG_OWN_MAC:  own_mac_ff  <= csr_wdata;
            REG_CACHE_TO: cache_to_ff <= csr_wdata[15:0];
            REG_PEND_TO:  pend_to_ff  <= csr_wdata[15:0];
            default:      own_ip_ff   <= own_ip_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      dest_ff <= dest_in;
      tip_ff  <= tip_in;
      tmac_ff <= tmac_in;
      if (accept) begin
         cmd_ff    <= req_cmd;
         op_req_ff <= (req_arp_op == 16'd1);
         shw_ff    <= req_sender_hw;
         sip_ff    <= req_sender_proto;
         tgt_ff    <= req_target_proto;
         nh_ff     <= req_next_hop_ip;
      end
      if (c_rec[CACHE_ENTRIES].go) begin
         c_res_ff <= c_rec[CACHE_ENTRIES];
      end
      if (p_rec[PENDING_ENTRIES].go) begin
         p_res_ff <= p_rec[PENDING_ENTRIES];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = act_ff;
   assign rsp_eth_dest    = own_mac_ff & '0 | dest_ff;
   assign rsp_arp_tgt_ip  = tip_ff;
   assign rsp_arp_tgt_mac = tmac_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not make the block busy");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without a finishing command");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_decide_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (c_done_ff && p_done_ff))
      else $error("decision taken before both rows finished the search");

endmodule
`default_nettype wire

// ----- design/are_cell.sv -----
// One table entry of the ARP resolver: holds IP, MAC and stamp, and folds
// itself into the search record passing by. Depends on are_pkg.
`default_nettype none
module are_cell
   import are_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [IDX_W-1:0] cell_idx,
   input  wire logic [31:0]      now_ticks,
   input  wire logic [15:0]      timeout,
   input  wire wr_type           wr,
   input  wire rec_type          rec_in,
   output rec_type               rec_out
);

   logic        valid_ff;
   logic [31:0] ip_ff;
   logic [47:0] mac_ff;
   logic [31:0] stamp_ff;
   rec_type     rec_out_ff;
   rec_type     rec_in_nx;
   logic [31:0] age;
   logic        live;
   logic        sel;

   assign age  = now_ticks - stamp_ff;
   assign live = valid_ff && (age <= {16'd0, timeout});
   assign sel  = (wr.idx == cell_idx);

   always_comb begin
      rec_in_nx = rec_in;
      if (!rec_in.hit && valid_ff && ip_ff == rec_in.key) begin
         rec_in_nx.hit      = 1'b1;
         rec_in_nx.hit_idx  = cell_idx;
         rec_in_nx.hit_live = live;
         rec_in_nx.hit_mac  = mac_ff;
      end
      if (!rec_in.free && !valid_ff) begin
         rec_in_nx.free     = 1'b1;
         rec_in_nx.free_idx = cell_idx;
      end
      if (!rec_in.exp && valid_ff && !live) begin
         rec_in_nx.exp     = 1'b1;
         rec_in_nx.exp_idx = cell_idx;
      end
      // Strictly older wins, so the lowest index keeps a tie.
      if (cell_idx == '0 || age > rec_in.best_age) begin
         rec_in_nx.best_idx = cell_idx;
         rec_in_nx.best_age = age;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (wr.en && sel) begin
         valid_ff <= 1'b1;
      end else if (wr.clr && sel) begin
         valid_ff <= 1'b0;
      end else if (wr.sweep && !live) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && sel) begin
         ip_ff    <= wr.ip;
         mac_ff   <= wr.mac;
         stamp_ff <= wr.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_out_ff <= '0;
      end else begin
         rec_out_ff <= rec_in_nx;
      end
   end

   assign rec_out = rec_out_ff;

endmodule
`default_nettype wire

// ----- dv/arp_resolver_engine_top_tb.sv -----
// Self-checking testbench for arp_resolver_engine_top: directed and random commands,
// checked against a cycle-free prediction of the ARP cache and pending store.
// Depends on are_pkg and the design under design/.
`default_nettype none
module arp_resolver_engine_top_tb
   import are_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] HW_ETHERNET   = 16'd1;
   localparam logic [15:0] PROTO_IPV4    = 16'h0800;
   localparam logic [7:0]  MAC_LEN       = 8'd6;
   localparam logic [7:0]  IPV4_LEN      = 8'd4;
   localparam logic [15:0] OP_REQUEST    = 16'd1;
   localparam logic [15:0] OP_REPLY      = 16'd2;
   localparam logic [10:0] MIN_FRAME_LEN = 11'd28;
   localparam logic [10:0] MAX_FRAME_LEN = 11'd1514;
   localparam int          POOL_SIZE     = 24;
   localparam int          PHASE_ITEMS   = 375;

   typedef struct {
      logic [1:0]  cmd;
      logic [10:0] frame_len;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_addr_len;
      logic [7:0]  proto_addr_len;
      logic [15:0] arp_op;
      logic [47:0] sender_hw;
      logic [31:0] sender_proto;
      logic [31:0] target_proto;
      logic [31:0] next_hop_ip;
   } arp_cmd_type;

   typedef struct {
      logic [2:0]  action;
      logic [47:0] eth_dest;
      logic [31:0] arp_tgt_ip;
      logic [47:0] arp_tgt_mac;
   } arp_rsp_type;

   // Holds the predicted cache, pending store and registers, plus the
   // responses still owed by the block.
   class arp_table_model;
      bit          c_valid [CACHE_ENTRIES];
      bit [31:0]   c_ip    [CACHE_ENTRIES];
      bit [47:0]   c_mac   [CACHE_ENTRIES];
      bit [31:0]   c_stamp [CACHE_ENTRIES];
      bit          p_valid [PENDING_ENTRIES];
      bit [31:0]   p_ip    [PENDING_ENTRIES];
      bit [31:0]   p_stamp [PENDING_ENTRIES];
      bit [31:0]   now_ticks;
      bit [31:0]   own_ip;
      bit [47:0]   own_mac;
      bit [31:0]   cache_to;
      bit [31:0]   pend_to;
      arp_rsp_type owed_rsp[$];
      int          errors;

      function new();
         foreach (c_valid[i]) c_valid[i] = 1'b0;
         foreach (p_valid[i]) p_valid[i] = 1'b0;
         now_ticks = 0;
         own_ip    = 0;
         own_mac   = 0;
         cache_to  = 60;
         pend_to   = 1;
         errors    = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [47:0] data);
         case (idx)
            REG_OWN_IP:   own_ip   = data[31:0];
            REG_OWN_MAC:  own_mac  = data;
            REG_CACHE_TO: cache_to = {16'd0, data[15:0]};
            REG_PEND_TO:  pend_to  = {16'd0, data[15:0]};
            default: ;
         endcase
      endfunction

      function bit live(bit v, bit [31:0] stamp, bit [31:0] limit);
         bit [31:0] age;
         age = now_ticks - stamp;
         return v && (age <= limit);
      endfunction

      // Same key, then lowest free, then lowest expired, then oldest.
      function int cache_slot(bit [31:0] key);
         int        best;
         bit [31:0] best_age;
         bit [31:0] age;
         best = 0;
         best_age = 0;
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (c_valid[i] && c_ip[i] == key) return i;
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!c_valid[i]) return i;
         for (int i = 0; i < CACHE_ENTRIES; i++)
            if (!live(1'b1, c_stamp[i], cache_to)) return i;
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            age = now_ticks - c_stamp[i];
            if (i == 0 || age > best_age) begin
               best = i;
               best_age = age;
            end
         end
         return best;
      endfunction

      function int pend_slot(bit [31:0] key);
         int        best;
         bit [31:0] best_age;
         bit [31:0] age;
         best = 0;
         best_age = 0;
         for (int i = 0; i < PENDING_ENTRIES; i++)
            if (p_valid[i] && p_ip[i] == key) return i;
         for (int i = 0; i < PENDING_ENTRIES; i++)
            if (!p_valid[i]) return i;
         for (int i = 0; i < PENDING_ENTRIES; i++)
            if (!live(1'b1, p_stamp[i], pend_to)) return i;
         for (int i = 0; i < PENDING_ENTRIES; i++) begin
            age = now_ticks - p_stamp[i];
            if (i == 0 || age > best_age) begin
               best = i;
               best_age = age;
            end
         end
         return best;
      endfunction

      function int find_pending(bit [31:0] ip);
         for (int i = 0; i < PENDING_ENTRIES; i++)
            if (live(p_valid[i], p_stamp[i], pend_to) && p_ip[i] == ip) return i;
         return -1;
      endfunction

      function void note_command(arp_cmd_type c);
         arp_rsp_type r;
         int          s;
         int          p;
         int          hit;
         bit          ok;
         r = '{ACT_NONE, 48'd0, 32'd0, 48'd0};
         case (c.cmd)
            CMD_FRAME: begin
               ok = c.frame_len >= MIN_FRAME_LEN && c.hw_type == HW_ETHERNET &&
                    c.proto_type == PROTO_IPV4 && c.hw_addr_len == MAC_LEN &&
                    c.proto_addr_len == IPV4_LEN &&
                    (c.arp_op == OP_REQUEST || c.arp_op == OP_REPLY);
               if (!ok) begin
                  r.action = ACT_REJECT;
               end else begin
                  s = cache_slot(c.sender_proto);
                  c_valid[s] = 1'b1;
                  c_ip[s]    = c.sender_proto;
                  c_mac[s]   = c.sender_hw;
                  c_stamp[s] = now_ticks;
                  p = find_pending(c.sender_proto);
                  if (p >= 0) begin
                     p_valid[p] = 1'b0;
                     r.action   = ACT_RELEASE;
                     r.eth_dest = c.sender_hw;
                  end else if (c.arp_op == OP_REQUEST && c.target_proto == own_ip) begin
                     r = '{ACT_REPLY, c.sender_hw, c.sender_proto, c.sender_hw};
                  end
               end
            end
            CMD_OUTBOUND: begin
               hit = -1;
               for (int i = 0; i < CACHE_ENTRIES; i++)
                  if (hit < 0 && live(c_valid[i], c_stamp[i], cache_to) &&
                      c_ip[i] == c.next_hop_ip) hit = i;
               if (hit >= 0) begin
                  r.action   = ACT_FORWARD;
                  r.eth_dest = c_mac[hit];
               end else if (find_pending(c.next_hop_ip) >= 0) begin
                  r.action = ACT_DROP;
               end else begin
                  s = pend_slot(c.next_hop_ip);
                  p_valid[s] = 1'b1;
                  p_ip[s]    = c.next_hop_ip;
                  p_stamp[s] = now_ticks;
                  r = '{ACT_REQUEST, MAC_BCAST, c.next_hop_ip, 48'd0};
               end
            end
            CMD_TICK: begin
               now_ticks++;
               for (int i = 0; i < CACHE_ENTRIES; i++)
                  if (!live(c_valid[i], c_stamp[i], cache_to)) c_valid[i] = 1'b0;
               for (int i = 0; i < PENDING_ENTRIES; i++)
                  if (!live(p_valid[i], p_stamp[i], pend_to)) p_valid[i] = 1'b0;
            end
            default: r = '{ACT_REQUEST, MAC_BCAST, own_ip, 48'd0};
         endcase
         owed_rsp.push_back(r);
      endfunction

      task report(string msg);
         $display("%0t ns: mismatch: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(arp_rsp_type got);
         arp_rsp_type want;
         if (owed_rsp.size() == 0) begin
            report($sformatf("response with none outstanding, action %0d", got.action));
         end else begin
            want = owed_rsp.pop_front();
            if (got.action !== want.action)
               report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.eth_dest !== want.eth_dest)
               report($sformatf("eth_dest %h, want %h", got.eth_dest, want.eth_dest));
            if (got.arp_tgt_ip !== want.arp_tgt_ip)
               report($sformatf("arp_tgt_ip %h, want %h", got.arp_tgt_ip, want.arp_tgt_ip));
            if (got.arp_tgt_mac !== want.arp_tgt_mac)
               report($sformatf("arp_tgt_mac %h, want %h", got.arp_tgt_mac, want.arp_tgt_mac));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [10:0] req_frame_len;
   logic [15:0] req_hw_type;
   logic [15:0] req_proto_type;
   logic [7:0]  req_hw_addr_len;
   logic [7:0]  req_proto_addr_len;
   logic [15:0] req_arp_op;
   logic [47:0] req_sender_hw;
   logic [31:0] req_sender_proto;
   logic [31:0] req_target_proto;
   logic [31:0] req_next_hop_ip;
   logic        rsp_valid;
   logic [2:0]  rsp_action;
   logic [47:0] rsp_eth_dest;
   logic [31:0] rsp_arp_tgt_ip;
   logic [47:0] rsp_arp_tgt_mac;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [47:0] csr_wdata;

   arp_table_model arp_model = new();
   logic [31:0]    ip_pool [POOL_SIZE];
   logic [47:0]    mac_pool[4];
   int             burst_left;

   arp_resolver_engine_top dut (.*);

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Outputs are sampled at the edge that ends the strobe cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         arp_model.check_response('{rsp_action, rsp_eth_dest, rsp_arp_tgt_ip, rsp_arp_tgt_mac});
   end

   initial begin
      #2_000_000;
      $display("arp_resolver_engine_top_tb failed");
      $finish;
   end

   function automatic logic [47:0] rand_mac();
      logic [63:0] t;
      t = {$urandom, $urandom};
      return t[47:0];
   endfunction

   function automatic arp_cmd_type noise_cmd();
      arp_cmd_type c;
      c.cmd            = 2'($urandom_range(0, 3));
      c.frame_len      = 11'($urandom_range(0, MAX_FRAME_LEN));
      c.hw_type        = 16'($urandom);
      c.proto_type     = 16'($urandom);
      c.hw_addr_len    = 8'($urandom);
      c.proto_addr_len = 8'($urandom);
      c.arp_op         = 16'($urandom);
      c.sender_hw      = rand_mac();
      c.sender_proto   = $urandom;
      c.target_proto   = $urandom;
      c.next_hop_ip    = $urandom;
      return c;
   endfunction

   function automatic arp_cmd_type arp_frame(logic [15:0] op, logic [31:0] sip,
                                             logic [47:0] shw, logic [31:0] tip);
      arp_cmd_type c;
      c = noise_cmd();
      c.cmd            = CMD_FRAME;
      c.frame_len      = 11'($urandom_range(MIN_FRAME_LEN, MAX_FRAME_LEN));
      c.hw_type        = HW_ETHERNET;
      c.proto_type     = PROTO_IPV4;
      c.hw_addr_len    = MAC_LEN;
      c.proto_addr_len = IPV4_LEN;
      c.arp_op         = op;
      c.sender_hw      = shw;
      c.sender_proto   = sip;
      c.target_proto   = tip;
      return c;
   endfunction

   function automatic arp_cmd_type with_cmd(logic [1:0] cmd, logic [31:0] hop);
      arp_cmd_type c;
      c = noise_cmd();
      c.cmd         = cmd;
      c.next_hop_ip = hop;
      return c;
   endfunction

   // Mostly well-formed traffic over a small address pool so that hits,
   // held packets, releases and replacements all occur.
   function automatic arp_cmd_type random_cmd();
      arp_cmd_type c;
      int          r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         c = arp_frame($urandom_range(0, 1) ? OP_REQUEST : OP_REPLY,
                       ip_pool[$urandom_range(0, POOL_SIZE - 1)],
                       $urandom_range(0, 2) != 0 ? mac_pool[$urandom_range(0, 3)] : rand_mac(),
                       $urandom_range(0, 1) ? arp_model.own_ip :
                                              ip_pool[$urandom_range(0, POOL_SIZE - 1)]);
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 5))
               0: c.frame_len      = 11'($urandom_range(0, MIN_FRAME_LEN - 1));
               1: c.hw_type        = 16'($urandom);
               2: c.proto_type     = 16'($urandom);
               3: c.hw_addr_len    = 8'($urandom);
               4: c.proto_addr_len = 8'($urandom);
               default: c.arp_op   = 16'($urandom);
            endcase
         end
      end else if (r < 72) begin
         c = with_cmd(CMD_OUTBOUND, $urandom_range(0, 9) != 0 ?
                                    ip_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom);
      end else if (r < 86) begin
         c = with_cmd(CMD_TICK, $urandom);
      end else if (r < 90) begin
         c = with_cmd(CMD_ANNOUNCE, $urandom);
      end else begin
         c = noise_cmd();
      end
      return c;
   endfunction

   // The beat is taken at the first edge with start high and busy low.
   task automatic send(arp_cmd_type c);
      req_cmd            <= c.cmd;
      req_frame_len      <= c.frame_len;
      req_hw_type        <= c.hw_type;
      req_proto_type     <= c.proto_type;
      req_hw_addr_len    <= c.hw_addr_len;
      req_proto_addr_len <= c.proto_addr_len;
      req_arp_op         <= c.arp_op;
      req_sender_hw      <= c.sender_hw;
      req_sender_proto   <= c.sender_proto;
      req_target_proto   <= c.target_proto;
      req_next_hop_ip    <= c.next_hop_ip;
      start              <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      arp_model.note_command(c);
      burst_left--;
      if (burst_left <= 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 20);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (arp_model.owed_rsp.size() != 0) @(posedge clock);
      repeat (CACHE_ENTRIES + 8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [47:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      arp_model.set_reg(idx, data);
   endtask

   task automatic set_config(logic [31:0] ip, logic [47:0] mac, logic [15:0] cto,
                             logic [15:0] pto);
      csr_write(REG_OWN_IP, {16'd0, ip});
      csr_write(REG_OWN_MAC, mac);
      csr_write(REG_CACHE_TO, {32'd0, cto});
      csr_write(REG_PEND_TO, {32'd0, pto});
      ip_pool[0] = ip;
      for (int i = 1; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
      foreach (mac_pool[i]) mac_pool[i] = rand_mac();
      mac_pool[0] = '1;
   endtask

   initial begin
      logic [31:0] ip_a;
      logic [31:0] ip_b;
      logic [47:0] mac_a;
      logic [15:0] cto;
      logic [15:0] pto;
      arp_cmd_type c;

      reset = 1'b1;
      start = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_cmd = '0;
      req_frame_len = '0;
      req_hw_type = '0;
      req_proto_type = '0;
      req_hw_addr_len = '0;
      req_proto_addr_len = '0;
      req_arp_op = '0;
      req_sender_hw = '0;
      req_sender_proto = '0;
      req_target_proto = '0;
      req_next_hop_ip = '0;
      burst_left = 5;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every action, each frame check, expiry of a held packet.
      set_config(32'h0A00_0001, 48'h0200_0000_0001, 16'd60, 16'd3);
      ip_a  = 32'hC0A8_0005;
      ip_b  = 32'hC0A8_0006;
      mac_a = 48'h0011_2233_4455;
      send(with_cmd(CMD_ANNOUNCE, 32'd0));
      send(with_cmd(CMD_OUTBOUND, ip_a));
      send(with_cmd(CMD_OUTBOUND, ip_a));
      send(arp_frame(OP_REPLY, ip_a, mac_a, 32'h0A00_0001));
      send(with_cmd(CMD_OUTBOUND, ip_a));
      send(arp_frame(OP_REQUEST, ip_b, '1, 32'h0A00_0001));
      send(arp_frame(OP_REQUEST, 32'hFFFF_FFFF, 48'd0, 32'h0A00_0002));
      c = arp_frame(OP_REQUEST, ip_b, mac_a, 32'h0A00_0001);
      c.frame_len = MIN_FRAME_LEN - 1;
      send(c);
      c.frame_len = MAX_FRAME_LEN;
      c.hw_type = 16'hFFFF;
      send(c);
      c.hw_type = HW_ETHERNET;
      c.proto_type = 16'h86DD;
      send(c);
      c.proto_type = PROTO_IPV4;
      c.hw_addr_len = 8'hFF;
      send(c);
      c.hw_addr_len = MAC_LEN;
      c.proto_addr_len = 8'd0;
      send(c);
      c.proto_addr_len = IPV4_LEN;
      c.arp_op = 16'd0;
      send(c);
      c.arp_op = 16'hFFFF;
      send(c);
      c.arp_op = OP_REQUEST;
      send(c);
      send(with_cmd(CMD_OUTBOUND, 32'd0));
      repeat (5) send(with_cmd(CMD_TICK, '1));
      send(with_cmd(CMD_OUTBOUND, 32'd0));
      send(with_cmd(CMD_OUTBOUND, ip_a));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin cto = 16'd1;     pto = 16'd1;     end
            1: begin cto = 16'hFFFF;  pto = 16'hFFFF;  end
            2: begin cto = 16'd3;     pto = 16'd2;     end
            default: begin
               cto = 16'($urandom_range(1, 8));
               pto = 16'($urandom_range(1, 8));
            end
         endcase
         set_config(ph == 1 ? 32'hFFFF_FFFF : (ph == 2 ? 32'd0 : $urandom),
                    ph == 1 ? 48'hFFFF_FFFF_FFFF : (ph == 2 ? 48'd0 : rand_mac()),
                    cto, pto);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Let the block run dry once in the middle of a phase.
            if (ph == 2 && n == PHASE_ITEMS / 2) drain();
            send(random_cmd());
         end
         drain();
      end

      if (arp_model.errors == 0 && arp_model.owed_rsp.size() == 0) begin
         $display("arp_resolver_engine_top_tb passed");
      end else begin
         $display("arp_resolver_engine_top_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
